// ===== rtl/cir_pkg.sv =====
// Shared types and constants for the clone image receiver.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package cir_pkg;

  // Raw action codes on the input channel
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IMAGE_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_CHECKSUM_POS  = 2'd1;
  localparam logic [1:0] CFG_BYTE_TIMEOUT  = 2'd2;
  localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd3;

  localparam int unsigned   STORE_INDEX_BITS = 16;
  localparam logic [7:0]    ACK_BYTE         = 8'h06;
  localparam int unsigned   FIRST_ACK_AT     = 10;
  localparam int unsigned   SECOND_ACK_AT    = 18;
  localparam int unsigned   IMAGE_LEN_RST    = 65535;
  localparam int unsigned   CHECKSUM_POS_RST = 65534;
  localparam int unsigned   BYTE_TMO_RST     = 500;
  localparam int unsigned   ACK_TMO_RST      = 200;

  localparam int unsigned   QUEUE_DEPTH = 2;
  localparam int unsigned   QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned   QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Decoded operation handed from front to back
  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_BYTE   = 2'd1,
    OP_TICK   = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_RECEIVING    = 3'd1,
    PH_AWAIT_ACK    = 3'd2,
    PH_DONE_OK      = 3'd3,
    PH_ACK_FAILED   = 3'd4,
    PH_TOO_SHORT    = 3'd5,
    PH_CHECKSUM_BAD = 3'd6
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic                        store_valid;
    logic [STORE_INDEX_BITS-1:0] store_index;
    logic [7:0]                  store_data;
    logic                        send_ack;
    phase_t                      status;
  } result_t;

endpackage

// ===== rtl/cir_front.sv =====
// Front end of the clone image receiver: takes input items and decodes the action.
// Depends on cir_pkg; feeds cir_queue.
`timescale 1ns / 1ps

module cir_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [7:0]           in_rx_data,
  input  cir_pkg::qstat_t      q_stat,
  output logic                 push,
  output cir_pkg::item_t       push_item
);
  import cir_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_action)
      ACT_START: op = OP_START;
      ACT_BYTE:  op = OP_BYTE;
      ACT_TICK:  op = OP_TICK;
      default:   op = OP_IGNORE;
    endcase
  end

  assign in_ready       = !q_stat.full;
  assign push           = in_valid && !q_stat.full;
  assign push_item.op   = op;
  // Only byte items carry data the back end looks at
  assign push_item.data = (op == OP_BYTE) ? in_rx_data : 8'h00;

endmodule

// ===== rtl/cir_queue.sv =====
// Short queue of decoded items between front and back end.
// Depends on cir_pkg.
`timescale 1ns / 1ps

module cir_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  cir_pkg::item_t   push_item,
  input  logic             pop,
  output cir_pkg::item_t   head,
  output cir_pkg::qstat_t  q_stat
);
  import cir_pkg::*;

  item_t                entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    if (p == QPTR_BITS'(QUEUE_DEPTH - 1)) return '0;
    else return p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_item;
  end

  assign head         = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// ===== rtl/cir_back.sv =====
// Back end of the clone image receiver: transfer state, timers, checksum and
// the result register. Depends on cir_pkg; pops items from cir_queue.
`timescale 1ns / 1ps

module cir_back #(
  parameter int INDEX_BITS = 16,
  parameter int TIMER_BITS = 24,
  parameter int CFG_BITS   = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cir_pkg::qstat_t       q_stat,
  input  cir_pkg::item_t        head,
  output logic                  pop,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cir_pkg::result_t      result
);
  import cir_pkg::*;

  logic [INDEX_BITS-1:0] image_len_r, checksum_pos_r;
  logic [TIMER_BITS-1:0] byte_tmo_r, ack_tmo_r;

  phase_t                phase_r, phase_nxt;
  logic [INDEX_BITS-1:0] count_r, count_nxt;
  logic [7:0]            sum_r, sum_nxt;
  logic [7:0]            chk_r, chk_nxt;
  logic [TIMER_BITS-1:0] gap_r, gap_nxt;
  logic [TIMER_BITS-1:0] ackt_r, ackt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  result_t               result_r, result_nxt;
  logic [INDEX_BITS-1:0] count_inc;

  assign pop       = !q_stat.empty && (!out_valid_r || out_ready);
  assign count_inc = count_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    chk_nxt   = chk_r;
    gap_nxt   = gap_r;
    ackt_nxt  = ackt_r;

    result_nxt.store_valid = 1'b0;
    result_nxt.store_index = '0;
    result_nxt.store_data  = '0;
    result_nxt.send_ack    = 1'b0;

    unique case (head.op)
      OP_START: begin
        phase_nxt = PH_RECEIVING;
        count_nxt = '0;
        sum_nxt   = '0;
        chk_nxt   = '0;
        gap_nxt   = '0;
        ackt_nxt  = '0;
      end
      OP_BYTE: begin
        if (phase_r == PH_RECEIVING) begin
          result_nxt.store_valid = 1'b1;
          result_nxt.store_index = STORE_INDEX_BITS'(count_r);
          result_nxt.store_data  = head.data;
          if (count_r < checksum_pos_r) sum_nxt = sum_r + head.data;
          else if (count_r == checksum_pos_r) chk_nxt = head.data;
          count_nxt = count_inc;
          gap_nxt   = '0;
          // completion wins over an ack point
          if (count_inc >= image_len_r) begin
            phase_nxt = (sum_nxt == chk_nxt) ? PH_DONE_OK : PH_CHECKSUM_BAD;
          end else if (count_inc == INDEX_BITS'(FIRST_ACK_AT) ||
                       count_inc == INDEX_BITS'(SECOND_ACK_AT)) begin
            result_nxt.send_ack = 1'b1;
            ackt_nxt  = '0;
            phase_nxt = PH_AWAIT_ACK;
          end
        end else if (phase_r == PH_AWAIT_ACK) begin
          if (head.data == ACK_BYTE) begin
            phase_nxt = PH_RECEIVING;
            gap_nxt   = '0;
          end else begin
            phase_nxt = PH_ACK_FAILED;
          end
        end
      end
      OP_TICK: begin
        if (phase_r == PH_RECEIVING) begin
          // no gap limit before the first byte
          if (count_r != '0) begin
            if (gap_r >= byte_tmo_r) phase_nxt = PH_TOO_SHORT;
            else gap_nxt = gap_r + 1'b1;
          end
        end else if (phase_r == PH_AWAIT_ACK) begin
          if (ackt_r >= ack_tmo_r) phase_nxt = PH_ACK_FAILED;
          else ackt_nxt = ackt_r + 1'b1;
        end
      end
      OP_IGNORE: begin
      end
    endcase

    result_nxt.status = phase_nxt;

    if (pop) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      chk_r       <= '0;
      gap_r       <= '0;
      ackt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
        chk_r   <= chk_nxt;
        gap_r   <= gap_nxt;
        ackt_r  <= ackt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result_r <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_len_r    <= INDEX_BITS'(IMAGE_LEN_RST);
      checksum_pos_r <= INDEX_BITS'(CHECKSUM_POS_RST);
      byte_tmo_r     <= TIMER_BITS'(BYTE_TMO_RST);
      ack_tmo_r      <= TIMER_BITS'(ACK_TMO_RST);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_LENGTH: image_len_r    <= cfg_wdata[INDEX_BITS-1:0];
        CFG_CHECKSUM_POS: checksum_pos_r <= cfg_wdata[INDEX_BITS-1:0];
        CFG_BYTE_TIMEOUT: byte_tmo_r     <= cfg_wdata[TIMER_BITS-1:0];
        CFG_ACK_TIMEOUT:  ack_tmo_r      <= cfg_wdata[TIMER_BITS-1:0];
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign result    = result_r;

endmodule

// ===== rtl/clone_image_receiver.sv =====
// Top level of the clone image receiver: front decode, item queue, back end.
// Depends on cir_pkg, cir_front, cir_queue and cir_back.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_action, in_rx_data
//   out      out_valid / out_ready  out_store_valid, out_store_index, out_store_data,
//                                   out_send_ack, out_status
//   cfg      cfg_we (no wait)       cfg_addr, cfg_wdata
//
// One item per cycle sustained while the output is not stalled; the back end updates the
// transfer state as it pops each item. An accepted item is first written into a queue entry,
// then, once the output is free, moves from the queue head into the result register.
// Reset is synchronous, active low; it restores the register defaults and an idle phase.
// A stalled output holds its result; the queue keeps taking items until it fills.
`timescale 1ns / 1ps

module clone_image_receiver #(
  parameter int INDEX_BITS = 16,
  parameter int TIMER_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_rx_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_store_valid,
  output logic [15:0] out_store_index,
  output logic [7:0]  out_store_data,
  output logic        out_send_ack,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [((TIMER_BITS > INDEX_BITS) ? TIMER_BITS : INDEX_BITS)-1:0] cfg_wdata
);
  import cir_pkg::*;

  localparam int CFG_BITS = (TIMER_BITS > INDEX_BITS) ? TIMER_BITS : INDEX_BITS;

  qstat_t  q_stat;
  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;
  result_t result;

  cir_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_action  (in_action),
    .in_rx_data (in_rx_data),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  cir_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  cir_back #(
    .INDEX_BITS (INDEX_BITS),
    .TIMER_BITS (TIMER_BITS),
    .CFG_BITS   (CFG_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign out_store_valid = result.store_valid;
  assign out_store_index = result.store_index;
  assign out_store_data  = result.store_data;
  assign out_send_ack    = result.send_ack;
  assign out_status      = result.status;

  // An ack request always leaves the transfer waiting for the reply
  a_ack_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_ack |-> out_status == PH_AWAIT_ACK)
    else $error("ack request without awaiting phase");

  // Non-byte results carry zero index and data
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_store_valid |-> out_store_index == '0 && out_store_data == '0)
    else $error("stray store payload");

  // A delivered byte leaves the transfer receiving, waiting or finished on length
  a_store_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_valid |->
      out_status == PH_RECEIVING || out_status == PH_AWAIT_ACK ||
      out_status == PH_DONE_OK || out_status == PH_CHECKSUM_BAD)
    else $error("store in wrong phase");

  // A queued item reaches the result register once the output is free
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty && (!out_valid || out_ready) |=> out_valid)
    else $error("queued item not drained");

endmodule
